// File: design/mcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types, mode codes and register indexes of the measurement cycle
// sequencer.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int SEC_W   = 16;
    localparam int FLAG_W  = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

    // latched flag bit positions
    localparam int F_CAL_TOOL   = 0;
    localparam int F_MEAS_TOOL  = 1;
    localparam int F_CALIBRATED = 2;
    localparam int F_DEPLETE    = 3;
    localparam int F_CIRCULATE  = 4;
    localparam int F_CAL_FIN    = 5;
    localparam int F_MEAS_FIN   = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_SECONDS         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_UP_SECONDS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_SECONDS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_WATER_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_WATER_SECONDS = 3'd4;

    typedef enum logic [3:0] {
        M_IDLE             = 4'd0,
        M_POWER_UP         = 4'd1,
        M_SHUTDOWN         = 4'd2,
        M_INIT             = 4'd3,
        M_CALIBRATION      = 4'd4,
        M_CALIBRATION_DONE = 4'd5,
        M_MEASUREMENT      = 4'd6,
        M_MEASUREMENT_DONE = 4'd7,
        M_FINALISE         = 4'd8,
        M_TAKE_DARK        = 4'd9,
        M_TAKE_SPECTRUM    = 4'd10,
        M_ANALYSE          = 4'd11,
        M_CHANGE_WATER     = 4'd12,
        M_SETTLE_WATER     = 4'd13,
        M_MANUAL_ON        = 4'd14,
        M_MANUAL_OFF       = 4'd15
    } t_mode;

    typedef struct packed {
        logic [SEC_W-1:0] idle_seconds;
        logic [SEC_W-1:0] power_up_seconds;
        logic [SEC_W-1:0] shutdown_seconds;
        logic [SEC_W-1:0] change_water_seconds;
        logic [SEC_W-1:0] settle_water_seconds;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        t_mode             resume_mode;
        t_mode             return_mode;
        logic [SEC_W-1:0]  rest_seconds;
        logic [SEC_W-1:0]  elapsed_seconds;
        logic              step_pending;
        logic [FLAG_W-1:0] latched_flags;
    } t_seq_state;

    localparam t_cfg CFG_RESET = '0;

    localparam t_seq_state SEQ_STATE_RESET = '{
        mode:            M_IDLE,
        resume_mode:     M_IDLE,
        return_mode:     M_IDLE,
        rest_seconds:    '0,
        elapsed_seconds: '0,
        step_pending:    1'b0,
        latched_flags:   '0
    };

    // leaving a timed mode restarts the seconds counter
    function automatic logic is_timed(input t_mode m);
        logic r;
        case (m)
            M_TAKE_DARK, M_TAKE_SPECTRUM, M_ANALYSE,
            M_MANUAL_ON, M_MANUAL_OFF: r = 1'b0;
            default:                   r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// File: design/mcs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_step
// Next-state function for one tick or step request: counter update, dwell
// check and mode transition.
// ----------------------------------------------------------------------------
module mcs_step import mcs_pkg::*; (
    input  t_seq_state        i_state,
    input  t_cfg              i_cfg,
    input  logic              i_cmd,
    input  logic [FLAG_W-1:0] i_flags,
    output t_seq_state        o_state,
    output logic              o_fire
);

    always_comb begin
        t_seq_state       s;
        logic [SEC_W-1:0] dwell;
        logic             ct;
        logic             mt;
        logic             cal;

        s = i_state;
        if (i_cmd) begin
            s.latched_flags = i_flags;
            s.step_pending  = 1'b1;
        end else if (s.elapsed_seconds != SEC_MAX) begin
            s.elapsed_seconds = s.elapsed_seconds + {{(SEC_W-1){1'b0}}, 1'b1};
        end

        case (i_state.mode)
            M_IDLE:                     dwell = i_state.rest_seconds;
            M_POWER_UP:                 dwell = i_cfg.power_up_seconds;
            M_SHUTDOWN:                 dwell = i_cfg.shutdown_seconds;
            M_CHANGE_WATER, M_FINALISE: dwell = i_cfg.change_water_seconds;
            M_SETTLE_WATER:             dwell = i_cfg.settle_water_seconds;
            default:                    dwell = '0;
        endcase

        o_fire = s.step_pending && (s.elapsed_seconds >= dwell);

        ct  = s.latched_flags[F_CAL_TOOL];
        mt  = s.latched_flags[F_MEAS_TOOL];
        cal = s.latched_flags[F_CALIBRATED];

        if (o_fire) begin
            case (i_state.mode)
                M_IDLE:     s.mode = M_POWER_UP;
                M_POWER_UP: s.mode = M_INIT;
                M_INIT: begin
                    if (ct && mt) begin
                        s.mode = cal ? M_MEASUREMENT : M_CALIBRATION;
                    end else if (ct) begin
                        s.mode = cal ? M_FINALISE : M_CALIBRATION;
                    end else if (!mt) begin
                        s.mode = M_MANUAL_ON;
                    end else begin
                        s.mode = M_FINALISE;
                    end
                end
                M_CALIBRATION: begin
                    if (s.latched_flags[F_DEPLETE]) begin
                        s.resume_mode = M_CALIBRATION;
                        s.mode        = M_CHANGE_WATER;
                    end else begin
                        s.return_mode = s.latched_flags[F_CAL_FIN] ?
                                        M_CALIBRATION_DONE : M_CALIBRATION;
                        if (s.latched_flags[F_CIRCULATE]) begin
                            s.resume_mode = M_TAKE_DARK;
                            s.mode        = M_CHANGE_WATER;
                        end else begin
                            s.mode = M_ANALYSE;
                        end
                    end
                end
                M_CALIBRATION_DONE: s.mode = M_FINALISE;
                M_MEASUREMENT: begin
                    s.return_mode = s.latched_flags[F_MEAS_FIN] ?
                                    M_MEASUREMENT_DONE : M_MEASUREMENT;
                    s.mode = M_TAKE_DARK;
                end
                M_MEASUREMENT_DONE: s.mode = M_FINALISE;
                M_TAKE_DARK:        s.mode = M_TAKE_SPECTRUM;
                M_TAKE_SPECTRUM:    s.mode = M_ANALYSE;
                M_ANALYSE:          s.mode = i_state.return_mode;
                M_CHANGE_WATER: begin
                    s.mode = s.latched_flags[F_DEPLETE] ?
                             i_state.resume_mode : M_SETTLE_WATER;
                end
                M_SETTLE_WATER: s.mode = i_state.resume_mode;
                M_FINALISE:     s.mode = M_SHUTDOWN;
                M_SHUTDOWN: begin
                    // idle rest never shorter than the settle time
                    s.rest_seconds = (i_cfg.idle_seconds < i_cfg.settle_water_seconds) ?
                                     i_cfg.settle_water_seconds : i_cfg.idle_seconds;
                    s.mode = M_IDLE;
                end
                M_MANUAL_ON: s.mode = M_MANUAL_OFF;
                default:     s.mode = M_SHUTDOWN;
            endcase
            if (is_timed(i_state.mode)) begin
                s.elapsed_seconds = '0;
            end
            s.step_pending = 1'b0;
        end

        o_state = s;
    end

endmodule

// File: design/measurement_cycle_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// measurement_cycle_sequencer
// Sixteen-mode instrument cycle sequencer driven by one-second ticks and
// step requests, reporting each mode change as an old/new mode pair.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item: tuser = 0 is a one-second tick,
//   tuser = 1 a step request whose tdata flags are latched for the step.
//   m_axis carries one result for every request that makes the mode
//   advance; ticks and requests that must still wait for the current
//   mode's dwell give no result.
//   The cfg channel writes the five dwell registers (index 0..4); other
//   indexes are dropped. Write only while the block is idle. Always ready.
// Timing:
//   A request is taken into an input register and evaluated by the single-pass
//   step logic once the output stage is free; its result is registered in the
//   output register. One request per cycle is sustained while m_axis is ready;
//   the only loop is the mode / counter register feeding the step logic.
// Reset (synchronous, active low):
//   mode, return and resume modes go to idle, counters, flags and all
//   dwell registers to zero, both pipeline stages empty.
// Stall:
//   While m_axis is stalled the pending result holds and one more request
//   is kept in the input register; s_axis_tready then drops.
// ----------------------------------------------------------------------------
module measurement_cycle_sequencer import mcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SEC_W-1:0]     i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] has_calibration_tool, [1] has_measurement_tool, [2] is_calibrated,
    // [3] deplete_water, [4] circulate_water, [5] calibration_finished,
    // [6] measurement_finished, [7] unused
    input  logic [7:0]           s_axis_tdata,
    // [0] cmd (0 tick, 1 step request)
    input  logic                 s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [3:0] old_mode, [7:4] new_mode
    output logic [7:0]           m_axis_tdata
);

    t_cfg              r_cfg;
    t_seq_state        r_state;
    t_seq_state        n_state;

    logic              r_in_valid;
    logic              r_in_cmd;
    logic [FLAG_W-1:0] r_in_flags;

    logic              r_out_valid;
    t_mode             r_out_old;
    t_mode             r_out_new;

    logic              step_fire;
    logic              advance;
    logic              in_take;
    logic              fire_taken;

    // output stage free or draining this cycle
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign fire_taken    = advance && r_in_valid && step_fire;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_new, r_out_old};

    mcs_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_cmd   (r_in_cmd),
        .i_flags (r_in_flags),
        .o_state (n_state),
        .o_fire  (step_fire)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IDLE_SECONDS:         r_cfg.idle_seconds         <= i_cfg_data;
                REG_POWER_UP_SECONDS:     r_cfg.power_up_seconds     <= i_cfg_data;
                REG_SHUTDOWN_SECONDS:     r_cfg.shutdown_seconds     <= i_cfg_data;
                REG_CHANGE_WATER_SECONDS: r_cfg.change_water_seconds <= i_cfg_data;
                REG_SETTLE_WATER_SECONDS: r_cfg.settle_water_seconds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control: stage valids and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= SEQ_STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && step_fire;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_flags <= s_axis_tdata[FLAG_W-1:0];
        end
        if (fire_taken) begin
            r_out_old <= r_state.mode;
            r_out_new <= n_state.mode;
        end
    end

`ifndef SYNTH
    // a fired step shows up as a result carrying the mode it left
    a_result_old_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_taken |=> r_out_valid && (r_out_old == $past(r_state.mode)))
        else $error("result old_mode does not match mode before step");

    // a fired step consumes the pending request
    a_pending_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_taken |=> !r_state.step_pending)
        else $error("step pending still set after step");

    // leaving shutdown loads a rest time of at least the settle time
    a_idle_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire_taken && (r_state.mode == M_SHUTDOWN)) |=>
        (r_state.rest_seconds >= $past(r_cfg.settle_water_seconds)) &&
        (r_state.mode == M_IDLE))
        else $error("idle rest time not clamped to settle time");

    // the input side only blocks while a request is held behind a stall
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free pipeline stage");
`endif

endmodule
